// ===== design/stscf_pkg.sv =====
// Shared constants, types and the tap coefficient table for the six-tap swept comb filter.
// Depends on nothing; the channel interfaces and the top level import it.
package stscf_pkg;

    // History ring geometry.
    localparam int RING_LEN = 2000;
    localparam int RING_AW  = $clog2(RING_LEN);
    localparam int FILL_W   = $clog2(RING_LEN + 1);

    // Sample and register widths.
    localparam int SMP_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int SCALE_W    = 11;
    localparam int LEVEL_W    = 24;

    localparam logic [CFG_DATA_W-1:0] UNITY_Q16   = 17'd65536;
    localparam logic [SCALE_W-1:0]    SCALE_RESET = 11'd256;
    localparam logic [LEVEL_W-1:0]    LEVEL_RESET = 24'd7063207;

    // Glide gain 0.0003 in Q0.24.
    localparam logic signed [13:0] GLIDE_TAKE = 14'sd5033;

    // Delay arithmetic widths.
    localparam int SQ_W    = 32;
    localparam int A_W     = 39;
    localparam int MUL_B_W = 18;
    localparam int B_W     = A_W + MUL_B_W - 16;
    localparam int DLY_W   = B_W + SCALE_W - 40;

    // 3.2 in Q.32, 3.85 in Q.16 and 41 in Q.32.
    localparam logic [A_W-1:0]     BASE_A = 39'd13743895347;
    localparam logic [MUL_B_W-1:0] MUL_B  = 18'd252314;
    localparam logic [B_W-1:0]     ADD_B  = B_W'(64'd41 << 32);

    // Tap sequencing.
    localparam int TAP_W    = 3;
    localparam int NUM_TAPS = 6;

    // Per-tap coefficients: group gain times tap weight, both Q.16, so Q.32 overall.
    localparam int COEF_W = 33;
    localparam logic signed [COEF_W-1:0] COEF_A_SIDE = 33'sd460148125;    // 17957 * 25625
    localparam logic signed [COEF_W-1:0] COEF_A_MID  = 33'sd1176829952;   // 17957 * 65536
    localparam logic signed [COEF_W-1:0] COEF_B_SIDE = -33'sd2479997964;  // -41222 * 60162
    localparam logic signed [COEF_W-1:0] COEF_B_MID  = -33'sd2701524992;  // -41222 * 65536

    localparam int PROD_W = SMP_W + COEF_W;
    localparam int ACC_W  = 59;
    localparam int WET_W  = ACC_W - 34;
    localparam int MIXP_W = WET_W + 1 + CFG_DATA_W + 1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET = 2'd0,
        CFG_WET    = 2'd1,
        CFG_SCALE  = 2'd2
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_GLIDE,
        S_SQUARE,
        S_BASE,
        S_SPAN,
        S_DLYB,
        S_TAP,
        S_DRAIN,
        S_MIX,
        S_OUT
    } t_state;

    function automatic logic signed [COEF_W-1:0] tap_coef(input logic [TAP_W-1:0] tap);
        logic signed [COEF_W-1:0] coef;
        unique case (tap)
            3'd0, 3'd2: coef = COEF_A_SIDE;
            3'd1:       coef = COEF_A_MID;
            3'd3, 3'd5: coef = COEF_B_SIDE;
            3'd4:       coef = COEF_B_MID;
            default:    coef = '0;
        endcase
        return coef;
    endfunction

endpackage

// ===== design/stscf_in_if.sv =====
// Input sample channel: valid/ready handshake carrying one audio sample.
// Depends on stscf_pkg for the sample width.
interface stscf_in_if;
    import stscf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink   (input valid, input in_sample, output ready);
endinterface

// ===== design/stscf_out_if.sv =====
// Output sample channel: valid/ready handshake carrying one filtered sample.
// Depends on stscf_pkg for the sample width.
interface stscf_out_if;
    import stscf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] out_sample;

    modport source (output valid, output out_sample, input ready);
    modport sink   (input valid, input out_sample, output ready);
endinterface

// ===== design/stscf_cfg_if.sv =====
// Configuration write channel: valid/ready handshake carrying a register index and data.
// Depends on stscf_pkg for the index and data widths.
interface stscf_cfg_if;
    import stscf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/stscf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Depends on nothing.
module stscf_ram #(
    parameter int  WIDTH = 24,
    parameter int  DEPTH = 2000,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/six_tap_swept_comb_filter.sv =====
// Six-tap swept comb filter top level: sequencer, delay arithmetic, tap accumulator and mix.
// Depends on stscf_pkg, the three channel interfaces and stscf_ram.

// Each input transaction carries one signed Q1.23 sample, which is written into a
// 2000-entry history memory, and yields exactly one output transaction. A smoothed level
// glides toward target_level on every sample; it sets two delays whose span follows the
// sample rate given by rate_scale, and three taps are read around each delay. The wet sum
// is mixed with the dry input by wet_mix and saturated to 24 bits. While the output side
// keeps up, each sample passes in order through the cycle in which the input is accepted,
// the delay arithmetic (glide, square, offset, and the two multiplies by rate_scale), the
// tap reads, one at a time through the single read port of the history memory, a drain
// while the last tap passes the coefficient multiplier and accumulator, and the wet/dry
// mix. The input is not ready again until the sequencer returns to idle, so a new sample
// is not taken while one is in progress. A finished result sits in an output register, so
// the next input is taken while it waits; a second result waits in the last step until
// the first is taken. The memory is not swept after reset: a fill count of the entries
// written since reset makes a tap that reaches an unwritten entry read as zero, so the
// block is ready straight out of reset. Configuration writes are taken at any time but
// should only be issued while no transaction is in progress.
module six_tap_swept_comb_filter (
    input logic         i_clk,
    input logic         i_rst_n,
    stscf_cfg_if.sink   i_cfg,
    stscf_in_if.sink    i_in_smp,
    stscf_out_if.source o_out_smp
);
    import stscf_pkg::*;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_target;
    logic [CFG_DATA_W-1:0] r_wet;
    logic [SCALE_W-1:0]    r_scale;

    // Sequencer.
    t_state            r_state;
    t_state            n_state;
    logic [TAP_W-1:0]  r_tap;

    // Persistent state outside the memory.
    logic [LEVEL_W-1:0] r_level;
    logic [RING_AW-1:0] r_wr_idx;
    logic [FILL_W-1:0]  r_fill;

    // Per-sample working registers.
    logic signed [SMP_W-1:0] r_x;
    logic [SQ_W-1:0]         r_sq;
    logic [A_W-1:0]          r_a;
    logic [B_W-1:0]          r_b;
    logic [DLY_W-1:0]        r_dly_a;
    logic [DLY_W-1:0]        r_dly_b;
    logic [DLY_W-1:0]        r_tap_dly;

    // Tap pipeline: read issued, then product, then accumulate.
    logic                     r_rd_vld;
    logic                     r_rd_hit;
    logic [TAP_W-1:0]         r_rd_tap;
    logic                     r_prod_vld;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [MIXP_W-1:0] r_mixp;

    // Output register.
    logic                    r_out_vld;
    logic signed [SMP_W-1:0] r_out_smp;

    // Control from the sequencer.
    logic in_ready;
    logic tap_issue;
    logic out_load;
    logic in_accept;

    // Clamped configuration values.
    logic [CFG_DATA_W-1:0] t_clamp;
    logic [CFG_DATA_W-1:0] w_clamp;

    // Datapath wires.
    logic signed [25:0]             glide_diff;
    logic signed [39:0]             glide_prod;
    logic signed [LEVEL_W:0]        glide_sum;
    logic [2*LEVEL_W-1:0]           lvl_sq;
    logic [A_W-1:0]                 a_next;
    logic [A_W+MUL_B_W-1:0]         b_prod;
    logic [A_W+SCALE_W-1:0]         da_prod;
    logic [B_W+SCALE_W-1:0]         db_prod;
    logic [SCALE_W+2:0]             scale7;
    logic [DLY_W-1:0]               span_a;
    logic [DLY_W-1:0]               span_b;
    logic [DLY_W-1:0]               dly_wrap;
    logic [RING_AW-1:0]             dly_mod;
    logic [RING_AW:0]               addr_sum;
    logic [RING_AW-1:0]             rd_addr;
    logic                           tap_hit;
    logic [SMP_W-1:0]               ram_rdata;
    logic signed [SMP_W-1:0]        tap_smp;
    logic signed [PROD_W-1:0]       tap_prod;
    logic signed [WET_W-1:0]        wet;
    logic signed [WET_W:0]          mix_diff;
    logic signed [MIXP_W-1:0]       mixp_next;
    logic signed [MIXP_W:0]         mix_sum;
    logic signed [MIXP_W-16:0]      mix_q;
    logic signed [SMP_W-1:0]        mix_sat;

    // The history memory: written once per sample, read once per tap.
    stscf_ram #(
        .WIDTH (SMP_W),
        .DEPTH (RING_LEN)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (in_accept),
        .i_waddr (r_wr_idx),
        .i_wdata (i_in_smp.in_sample),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    assign i_cfg.ready      = 1'b1;
    assign i_in_smp.ready   = in_ready;
    assign in_accept        = i_in_smp.valid && in_ready;
    assign o_out_smp.valid  = r_out_vld;
    assign o_out_smp.out_sample = r_out_smp;

    // Targets and wet amounts above one are treated as one.
    assign t_clamp = (r_target > UNITY_Q16) ? UNITY_Q16 : r_target;
    assign w_clamp = (r_wet > UNITY_Q16) ? UNITY_Q16 : r_wet;

    // The glide keep and take gains sum to one, so the update is
    // level + floor((target - level) * take), which needs a single multiply.
    assign glide_diff = $signed({1'b0, t_clamp, 8'd0}) - $signed({2'b0, r_level});
    assign glide_prod = glide_diff * GLIDE_TAKE;
    assign glide_sum  = $signed({1'b0, r_level}) + $signed(glide_prod[39:24]);

    assign lvl_sq = r_level * r_level;
    assign a_next = r_sq * A_W'(77) + BASE_A;
    assign b_prod = r_a * MUL_B;
    assign da_prod = r_a * r_scale;
    assign db_prod = r_b * r_scale;

    // Spacing between the taps of each group.
    assign scale7 = r_scale * 3'd7;
    assign span_a = DLY_W'(r_scale[SCALE_W-1:8]);
    assign span_b = DLY_W'(scale7[SCALE_W+2:8]);

    // The longest delay stays below twice the ring length, so one conditional subtract
    // folds it into the ring; a second one wraps the address.
    assign dly_wrap = (r_tap_dly >= DLY_W'(RING_LEN)) ? r_tap_dly - DLY_W'(RING_LEN)
                                                        : r_tap_dly;
    assign dly_mod  = dly_wrap[RING_AW-1:0];
    assign addr_sum = {1'b0, r_wr_idx} + {1'b0, dly_mod};
    assign rd_addr  = (addr_sum >= (RING_AW+1)'(RING_LEN))
                    ? RING_AW'(addr_sum - (RING_AW+1)'(RING_LEN))
                    : addr_sum[RING_AW-1:0];

    // Entries not written since reset read as zero.
    assign tap_hit = FILL_W'(dly_mod) < r_fill;

    assign tap_smp  = r_rd_hit ? $signed(ram_rdata) : '0;
    assign tap_prod = tap_smp * tap_coef(r_rd_tap);

    // Mix: x*(1 - w) + wet*w is rewritten as x + (wet - x)*w.
    assign wet       = r_acc[ACC_W-1:34];
    assign mix_diff  = wet - r_x;
    assign mixp_next = mix_diff * $signed({1'b0, w_clamp});
    assign mix_sum   = {{(MIXP_W+1-SMP_W-16){r_x[SMP_W-1]}}, r_x, 16'd0}
                     + {r_mixp[MIXP_W-1], r_mixp};
    assign mix_q     = mix_sum[MIXP_W:16];

    always_comb begin
        if (!mix_q[MIXP_W-16] && (|mix_q[MIXP_W-17:SMP_W-1])) begin
            mix_sat = {1'b0, {(SMP_W-1){1'b1}}};
        end else if (mix_q[MIXP_W-16] && !(&mix_q[MIXP_W-17:SMP_W-1])) begin
            mix_sat = {1'b1, {(SMP_W-1){1'b0}}};
        end else begin
            mix_sat = mix_q[SMP_W-1:0];
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_smp.valid) begin
                    n_state = S_GLIDE;
                end
            end
            S_GLIDE:  n_state = S_SQUARE;
            S_SQUARE: n_state = S_BASE;
            S_BASE:   n_state = S_SPAN;
            S_SPAN:   n_state = S_DLYB;
            S_DLYB:   n_state = S_TAP;
            S_TAP: begin
                if (r_tap == TAP_W'(NUM_TAPS - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The last product accumulates on the edge that leaves this state.
                if (!r_rd_vld) begin
                    n_state = S_MIX;
                end
            end
            S_MIX: n_state = S_OUT;
            S_OUT: begin
                if (!r_out_vld || o_out_smp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        in_ready  = 1'b0;
        tap_issue = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: in_ready  = 1'b1;
            S_TAP:  tap_issue = 1'b1;
            S_OUT:  out_load  = !r_out_vld || o_out_smp.ready;
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_target   <= '0;
            r_wet      <= UNITY_Q16;
            r_scale    <= SCALE_RESET;
            r_level    <= LEVEL_RESET;
            r_wr_idx   <= '0;
            r_fill     <= '0;
            r_tap      <= '0;
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= tap_issue;
            r_prod_vld <= r_rd_vld;

            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_TARGET: r_target <= i_cfg.data;
                    CFG_WET:    r_wet    <= i_cfg.data;
                    CFG_SCALE:  r_scale  <= i_cfg.data[SCALE_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (in_accept && (r_fill != FILL_W'(RING_LEN))) begin
                r_fill <= r_fill + 1'b1;
            end

            if (r_state == S_GLIDE) begin
                r_level <= glide_sum[LEVEL_W-1:0];
            end

            if (r_state == S_DLYB) begin
                r_tap <= '0;
            end else if (tap_issue) begin
                r_tap <= r_tap + 1'b1;
            end

            // The write position walks downward through the ring, one entry per sample.
            if (out_load) begin
                r_out_vld <= 1'b1;
                r_wr_idx  <= (r_wr_idx == '0) ? RING_AW'(RING_LEN - 1) : r_wr_idx - 1'b1;
            end else if (o_out_smp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_x   <= i_in_smp.in_sample;
            r_acc <= {{(ACC_W-SMP_W-32){i_in_smp.in_sample[SMP_W-1]}},
                      i_in_smp.in_sample, 32'd0};
        end else if (r_prod_vld) begin
            r_acc <= r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end

        if (r_state == S_SQUARE) begin
            r_sq <= lvl_sq[2*LEVEL_W-1:16];
        end
        if (r_state == S_BASE) begin
            r_a <= a_next;
        end
        if (r_state == S_SPAN) begin
            r_b     <= b_prod[A_W+MUL_B_W-1:16] + ADD_B;
            r_dly_a <= DLY_W'(da_prod[A_W+SCALE_W-1:40]);
        end
        if (r_state == S_DLYB) begin
            r_dly_b   <= db_prod[B_W+SCALE_W-1:40];
            r_tap_dly <= r_dly_a;
        end else if (tap_issue) begin
            // Taps go A, A+wA, A+2wA, then B, B+wB, B+2wB.
            unique case (r_tap)
                3'd0, 3'd1: r_tap_dly <= r_tap_dly + span_a;
                3'd2:       r_tap_dly <= r_dly_b;
                default:    r_tap_dly <= r_tap_dly + span_b;
            endcase
        end

        r_rd_tap <= r_tap;
        r_rd_hit <= tap_hit;
        r_prod   <= tap_prod;

        if (r_state == S_MIX) begin
            r_mixp <= mixp_next;
        end
        if (out_load) begin
            r_out_smp <= mix_sat;
        end
    end

endmodule
